// ===== design/uvs_pkg.sv =====
package uvs_pkg;

  localparam int MAX_RINGS        = 256;
  localparam int MAX_COLUMNS      = 256;
  localparam int SINE_TABLE_DEPTH = 1024;

  // Configuration register indexes
  localparam logic [1:0] REG_LAT_COUNT = 2'd0;
  localparam logic [1:0] REG_LON_COUNT = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;

  // Reciprocal of six: exact floor(n / 6) for any 19-bit n as (n * DIV6_MUL) >> DIV6_SHIFT
  localparam logic [19:0] DIV6_MUL   = 20'd699051;
  localparam int          DIV6_SHIFT = 22;

  // Quarter-turn sine polynomial, Q30
  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598343;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026994;
  localparam logic [63:0] POLY_C9 = 64'd172272;

  localparam int QSIN_DEPTH = 256;
  localparam logic [15:0] QSIN_PEAK = 16'd32768;

  typedef logic [15:0] qsin_tab_t [QSIN_DEPTH];

  // Item handed from the classifier to the datapath
  typedef struct packed {
    logic        oor;
    logic [2:0]  corner;
    logic [15:0] quad;
  } item_t;

  // Effective geometry after clamping
  typedef struct packed {
    logic [8:0]  cols;
    logic [7:0]  bands;
    logic [14:0] radius;
  } geom_t;

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t   tab;
    logic [63:0] z;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] r;
    for (int k = 0; k < QSIN_DEPTH; k++) begin
      z = 64'(k) << 22;
      u = (z * z) >> 30;
      s = POLY_C9;
      s = POLY_C7 - ((u * s) >> 30);
      s = POLY_C5 - ((u * s) >> 30);
      s = POLY_C3 - ((u * s) >> 30);
      s = POLY_C1 - ((u * s) >> 30);
      r = (z * s) >> 30;
      r = (r + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      tab[k] = r[15:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // Sine of a 10-bit phase (1024 steps per turn), Q15 in [-32768, 32768]
  function automatic logic signed [16:0] phase_sine(input logic [9:0] p);
    logic [8:0]  kk;
    logic [15:0] m;
    if (p[8]) begin
      kk = 9'd256 - {1'b0, p[7:0]};
      m  = kk[8] ? QSIN_PEAK : QSIN_TAB[kk[7:0]];
    end else begin
      kk = {1'b0, p[7:0]};
      m  = QSIN_TAB[kk[7:0]];
    end
    return p[9] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Q15 times Q15, rounded half away from zero
  function automatic logic signed [16:0] mul_q15(input logic signed [16:0] a,
                                                 input logic signed [16:0] b);
    logic        neg;
    logic [16:0] ma;
    logic [16:0] mb;
    logic [33:0] pr;
    logic [16:0] m;
    neg = a[16] ^ b[16];
    ma  = a[16] ? 17'(-a) : 17'(a);
    mb  = b[16] ? 17'(-b) : 17'(b);
    pr  = 34'(ma) * 34'(mb) + 34'd16384;
    m   = pr[31:15];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'h7FFF;
    end else if (v < -17'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic corner_col(input logic [2:0] k);
    case (k)
      3'd1, 3'd2, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic corner_ring(input logic [2:0] k);
    case (k)
      3'd1, 3'd4, 3'd5: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

endpackage

// ===== design/uvs_front.sv =====
module uvs_front
  import uvs_pkg::*;
(
  input  logic [18:0] vertex_number,
  input  logic [18:0] limit,
  output item_t       item
);

  logic [38:0] prod;
  logic [16:0] quad;
  logic [19:0] rem;

  // Split into quad and corner, flag numbers past the vertex count
  always_comb begin
    prod        = 39'(vertex_number) * 39'(DIV6_MUL);
    quad        = prod[38:DIV6_SHIFT];
    rem         = 20'(vertex_number) - {1'b0, quad, 2'b00} - {2'b00, quad, 1'b0};
    item.oor    = (vertex_number >= limit);
    item.corner = rem[2:0];
    item.quad   = quad[15:0];
  end

endmodule

// ===== design/uvs_queue.sv =====
module uvs_queue
  import uvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int DEPTH = 4;

  item_t       mem_r [DEPTH];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;

  assign full  = (count_r == 3'(DEPTH));
  assign empty = (count_r == 3'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== design/uvs_back.sv =====
module uvs_back
  import uvs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  geom_t         geom,
  input  logic          q_empty,
  input  item_t         q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [129:0]  out_data,
  output logic          out_flag
);

  localparam int D1_STEPS = 16;
  localparam int D2_STEPS = 17;

  typedef struct packed {
    logic        oor;
    logic [2:0]  corner;
    logic [15:0] num;
    logic [7:0]  rem;
  } d1_t;

  typedef struct packed {
    logic        oor;
    logic [7:0]  ra;
    logic [16:0] fq;
    logic [7:0]  rb;
    logic [17:0] gq;
  } d2_t;

  typedef struct packed {
    logic               oor;
    logic signed [16:0] st;
    logic signed [16:0] ct;
    logic signed [16:0] sp;
    logic signed [16:0] cp;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } trig_t;

  typedef struct packed {
    logic               oor;
    logic signed [16:0] ux;
    logic signed [16:0] uy;
    logic signed [16:0] uz;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } unit_t;

  logic adv;

  d1_t   d1_r [D1_STEPS + 1];
  logic  v1_r [D1_STEPS + 1];
  d2_t   d2_r [D2_STEPS + 1];
  logic  v2_r [D2_STEPS + 1];
  trig_t tr_r;
  logic  vt_r;
  unit_t un_r;
  logic  vu_r;
  logic [129:0] out_data_r;
  logic         out_flag_r;
  logic         out_valid_r;

  d1_t   d1_nxt [D1_STEPS + 1];
  d2_t   d2_nxt [D2_STEPS + 1];
  trig_t tr_nxt;
  unit_t un_nxt;
  logic [129:0] out_data_nxt;

  // Whole datapath advances together whenever the output register can move
  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_flag  = out_flag_r;

  always_comb begin
    logic [8:0]  t1;
    logic [8:0]  ta;
    logic [8:0]  tb;
    logic [8:0]  col;
    logic [7:0]  ring;
    logic [16:0] fh;
    logic [16:0] gh;
    logic [10:0] pt;
    logic [9:0]  pp;
    logic [17:0] us;
    logic [18:0] vs;

    // Load: quad / bands, one quotient bit per stage
    d1_nxt[0].oor    = q_head.oor;
    d1_nxt[0].corner = q_head.corner;
    d1_nxt[0].num    = q_head.quad;
    d1_nxt[0].rem    = '0;
    for (int s = 1; s <= D1_STEPS; s++) begin
      d1_nxt[s] = d1_r[s-1];
      t1 = {d1_r[s-1].rem, d1_r[s-1].num[15]};
      if (t1 >= {1'b0, geom.bands}) begin
        t1 = t1 - {1'b0, geom.bands};
        d1_nxt[s].num = {d1_r[s-1].num[14:0], 1'b1};
      end else begin
        d1_nxt[s].num = {d1_r[s-1].num[14:0], 1'b0};
      end
      d1_nxt[s].rem = t1[7:0];
    end

    // Grid point, then column and ring fractions share the next stages
    col  = d1_r[D1_STEPS].num[8:0] + 9'(corner_col(d1_r[D1_STEPS].corner));
    ring = d1_r[D1_STEPS].rem + 8'(corner_ring(d1_r[D1_STEPS].corner));
    if (col >= geom.cols) begin
      col = '0;
    end
    d2_nxt[0].oor = d1_r[D1_STEPS].oor;
    d2_nxt[0].ra  = col[7:0];
    d2_nxt[0].fq  = '0;
    if (ring == geom.bands) begin
      d2_nxt[0].rb = '0;
      d2_nxt[0].gq = 18'd1;
    end else begin
      d2_nxt[0].rb = ring;
      d2_nxt[0].gq = '0;
    end
    for (int s = 1; s <= D2_STEPS; s++) begin
      d2_nxt[s] = d2_r[s-1];
      ta = {d2_r[s-1].ra, 1'b0};
      if (ta >= geom.cols) begin
        ta = ta - geom.cols;
        d2_nxt[s].fq = {d2_r[s-1].fq[15:0], 1'b1};
      end else begin
        d2_nxt[s].fq = {d2_r[s-1].fq[15:0], 1'b0};
      end
      d2_nxt[s].ra = ta[7:0];
      tb = {d2_r[s-1].rb, 1'b0};
      if (tb >= {1'b0, geom.bands}) begin
        tb = tb - {1'b0, geom.bands};
        d2_nxt[s].gq = {d2_r[s-1].gq[16:0], 1'b1};
      end else begin
        d2_nxt[s].gq = {d2_r[s-1].gq[16:0], 1'b0};
      end
      d2_nxt[s].rb = tb[7:0];
    end

    // Phases, texture coordinates and sine lookups
    fh = {1'b0, d2_r[D2_STEPS].fq[16:1]};
    gh = d2_r[D2_STEPS].gq[17:1];
    pt = 11'((fh + 17'd32) >> 6);
    pp = 10'((gh + 17'd64) >> 7);
    us = 18'(d2_r[D2_STEPS].fq) + 18'd1;
    vs = 19'(d2_r[D2_STEPS].gq) + 19'd1;
    tr_nxt.oor   = d2_r[D2_STEPS].oor;
    tr_nxt.st    = phase_sine(pt[9:0]);
    tr_nxt.ct    = phase_sine(pt[9:0] + 10'd256);
    tr_nxt.sp    = phase_sine(pp);
    tr_nxt.cp    = phase_sine(pp + 10'd256);
    tr_nxt.tex_u = us[17:1];
    tr_nxt.tex_v = vs[17:1];

    // Unit vector
    un_nxt.oor   = tr_r.oor;
    un_nxt.ux    = mul_q15(tr_r.sp, tr_r.st);
    un_nxt.uy    = tr_r.cp;
    un_nxt.uz    = mul_q15(tr_r.ct, tr_r.sp);
    un_nxt.tex_u = tr_r.tex_u;
    un_nxt.tex_v = tr_r.tex_v;

    // Scale by radius, saturate, zero past the vertex count
    if (un_r.oor) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = {un_r.tex_v, un_r.tex_u,
                      sat16(un_r.uz), sat16(un_r.uy), sat16(un_r.ux),
                      sat16(mul_q15($signed({2'b00, geom.radius}), un_r.uz)),
                      sat16(mul_q15($signed({2'b00, geom.radius}), un_r.uy)),
                      sat16(mul_q15($signed({2'b00, geom.radius}), un_r.ux))};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= D1_STEPS; s++) begin
        d1_r[s] <= d1_nxt[s];
      end
      for (int s = 0; s <= D2_STEPS; s++) begin
        d2_r[s] <= d2_nxt[s];
      end
      tr_r       <= tr_nxt;
      un_r       <= un_nxt;
      out_data_r <= out_data_nxt;
      out_flag_r <= un_r.oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= D1_STEPS; s++) begin
        v1_r[s] <= 1'b0;
      end
      for (int s = 0; s <= D2_STEPS; s++) begin
        v2_r[s] <= 1'b0;
      end
      vt_r        <= 1'b0;
      vu_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r[0] <= !q_empty;
      for (int s = 1; s <= D1_STEPS; s++) begin
        v1_r[s] <= v1_r[s-1];
      end
      v2_r[0] <= v1_r[D1_STEPS];
      for (int s = 1; s <= D2_STEPS; s++) begin
        v2_r[s] <= v2_r[s-1];
      end
      vt_r        <= v2_r[D2_STEPS];
      vu_r        <= vt_r;
      out_valid_r <= vu_r;
    end
  end

endmodule

// ===== design/uv_sphere_vertex_generator.sv =====
// UV-sphere triangle-list vertex generator. Each transaction on the input
// stream names one vertex of the flattened triangle list (six per quad, two
// triangles); the block answers with one transaction carrying the grid
// point's position (radius times the unit vector, Q1.15), its unit normal
// (Q1.15, saturated) and texture coordinates (Q0.16, 65536 = 1.0). Numbers at
// or past lon_count * (lat_count - 1) * 6 come back with out_tuser set and all
// other fields zero. The block sustains one transaction per clock while the
// result stream is not stalled. A result passes through the classifier
// queue, 17 registers for the strip/band split (load plus 16 divider
// stages), 18 registers for the column and ring fractions (load plus 17
// divider stages), and three trigonometry and scaling stages. A stalled
// result stream freezes the whole back end, and the four-entry queue then
// fills before in_tready drops. Write the configuration only while the
// block is idle; the clamped geometry is registered from the written values.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [18:0] vertex_number, rest zero
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y,
                                   // norm_z (16 each), tex_u, tex_v (17 each)
  output logic         out_tuser   // out_of_range
);

  logic [8:0]  lat_r;
  logic [8:0]  lon_r;
  logic [14:0] radius_r;
  geom_t       geom_r;
  geom_t       geom_nxt;
  logic [18:0] limit_r;
  logic [18:0] limit_nxt;

  item_t       front_item;
  item_t       q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic [129:0] out_data;

  assign cfg_ready = 1'b1;

  // Register file: keep only each register's width, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r    <= 9'd16;
      lon_r    <= 9'd16;
      radius_r <= 15'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAT_COUNT: lat_r    <= cfg_data[8:0];
        REG_LON_COUNT: lon_r    <= cfg_data[8:0];
        REG_RADIUS:    radius_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry and precompute the vertex count
  always_comb begin
    logic [8:0]  rings;
    logic [8:0]  bands9;
    logic [16:0] cb;
    rings = lat_r;
    if (lat_r < 9'd2) begin
      rings = 9'd2;
    end else if (lat_r > 9'(MAX_RINGS)) begin
      rings = 9'(MAX_RINGS);
    end
    geom_nxt.cols = lon_r;
    if (lon_r < 9'd1) begin
      geom_nxt.cols = 9'd1;
    end else if (lon_r > 9'(MAX_COLUMNS)) begin
      geom_nxt.cols = 9'(MAX_COLUMNS);
    end
    bands9          = rings - 9'd1;
    geom_nxt.bands  = bands9[7:0];
    geom_nxt.radius = radius_r;
    cb              = 17'(geom_nxt.cols) * 17'(bands9[7:0]);
    limit_nxt       = {cb, 2'b00} + {1'b0, cb, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r  <= '{cols: 9'd16, bands: 8'd15, radius: 15'd16384};
      limit_r <= 19'd1440;
    end else begin
      geom_r  <= geom_nxt;
      limit_r <= limit_nxt;
    end
  end

  // Front: classify and queue while the queue has room
  assign in_tready = !q_full;

  uvs_front u_front (
    .vertex_number (in_tdata[18:0]),
    .limit         (limit_r),
    .item          (front_item)
  );

  uvs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: divide, look up sines, scale; stalls only on the result stream
  uvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_flag  (out_tuser)
  );

  assign out_tdata = {6'b0, out_data};

endmodule
